// ===== src/chacha20_stream_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// chacha20 stream cipher assertion macros
// shared helpers for the concurrent checks on the cipher ports
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// check that is switched off while reset is held
`define CC20_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs while reset is held
`define CC20_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// types, constants and round functions of the chacha20 stream cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc20_pkg;

  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0][31:0]  quad_t;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_NONCE_01 = 3'd4;
  localparam logic [2:0] REG_NONCE_2  = 3'd5;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cfg_t;

  // one classified word on its way to the back end
  typedef struct packed {
    logic [31:0] text;
    logic        gen;
    logic [3:0]  pos;
    logic [31:0] blk;
  } entry_t;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // q[0..3] = a, b, c, d
  function automatic quad_t qround(quad_t q);
    logic [31:0] a, b, c, d;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  // column round when diag is low, diagonal round when high
  function automatic block_t half_round(block_t s, logic diag);
    block_t r;
    quad_t  q0, q1, q2, q3;
    if (!diag) begin
      q0 = qround({s[12], s[8],  s[4], s[0]});
      q1 = qround({s[13], s[9],  s[5], s[1]});
      q2 = qround({s[14], s[10], s[6], s[2]});
      q3 = qround({s[15], s[11], s[7], s[3]});
      r[0] = q0[0]; r[4] = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
      r[1] = q1[0]; r[5] = q1[1]; r[9]  = q1[2]; r[13] = q1[3];
      r[2] = q2[0]; r[6] = q2[1]; r[10] = q2[2]; r[14] = q2[3];
      r[3] = q3[0]; r[7] = q3[1]; r[11] = q3[2]; r[15] = q3[3];
    end else begin
      q0 = qround({s[15], s[10], s[5], s[0]});
      q1 = qround({s[12], s[11], s[6], s[1]});
      q2 = qround({s[13], s[8],  s[7], s[2]});
      q3 = qround({s[14], s[9],  s[4], s[3]});
      r[0] = q0[0]; r[5] = q0[1]; r[10] = q0[2]; r[15] = q0[3];
      r[1] = q1[0]; r[6] = q1[1]; r[11] = q1[2]; r[12] = q1[3];
      r[2] = q2[0]; r[7] = q2[1]; r[8]  = q2[2]; r[13] = q2[3];
      r[3] = q3[0]; r[4] = q3[1]; r[9]  = q3[2]; r[14] = q3[3];
    end
    return r;
  endfunction

  function automatic block_t init_block(cfg_t cfg, logic [31:0] blk);
    block_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      s[4 + i] = cfg.key[i];
    end
    s[12] = blk;
    s[13] = cfg.nonce[0];
    s[14] = cfg.nonce[1];
    s[15] = cfg.nonce[2];
    return s;
  endfunction

endpackage

// ===== src/cc20_fifo.sv =====
// ----------------------------------------------------------------------------
// cc20_fifo
// short queue of classified words between front end and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cc20_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output cc20_pkg::entry_t  head_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned Depth = cc20_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cc20_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== src/cc20_front.sv =====
// ----------------------------------------------------------------------------
// cc20_front
// accepts words, tracks position and block counter, marks block starts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [31:0]       text_word_i,
  input  logic              message_start_i,
  output logic              in_stall_o,
  input  logic              fifo_full_i,
  output logic              push_o,
  output cc20_pkg::entry_t  entry_o
);

  logic [3:0]  pos_q, pos_d, pos_cur;
  logic [31:0] blk_q, blk_d, blk_cur;

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // message start restarts at block 0, word 0
  assign pos_cur = message_start_i ? 4'd0 : pos_q;
  assign blk_cur = message_start_i ? 32'd0 : blk_q;

  assign entry_o.text = text_word_i;
  assign entry_o.gen  = (pos_cur == 4'd0);
  assign entry_o.pos  = pos_cur;
  assign entry_o.blk  = blk_cur;

  always_comb begin
    pos_d = pos_q;
    blk_d = blk_q;
    if (push_o) begin
      pos_d = pos_cur + 4'd1;
      blk_d = (pos_cur == 4'd15) ? blk_cur + 32'd1 : blk_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      blk_q <= '0;
    end else begin
      pos_q <= pos_d;
      blk_q <= blk_d;
    end
  end

endmodule

// ===== src/cc20_back.sv =====
// ----------------------------------------------------------------------------
// cc20_back
// block generator with keystream buffer and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_back #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cc20_pkg::cfg_t    cfg_i,
  input  cc20_pkg::entry_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output logic [31:0]       crypt_word_o,
  input  logic              out_stall_i
);

  localparam int unsigned HalfRounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned CntW       = $clog2(HalfRounds);
  localparam logic [CntW-1:0] LastCnt = CntW'(HalfRounds - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ADD,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_word_q, out_word_d;
  cc20_pkg::block_t  work_q, work_d;
  cc20_pkg::block_t  ks_q;
  cc20_pkg::block_t  init_w, round_w;
  logic              slot_free, load, feed_fwd;

  assign init_w    = cc20_pkg::init_block(cfg_i, head_i.blk);
  assign round_w   = cc20_pkg::half_round(work_q, cnt_q[0]);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    feed_fwd    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (head_i.gen) begin
            load    = 1'b1;
            cnt_d   = '0;
            state_d = S_RUN;
          end else if (slot_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_word_d  = head_i.text ^ ks_q[head_i.pos];
          end
        end
      end
      S_RUN: begin
        if (cnt_q == LastCnt) begin
          state_d = S_ADD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ADD: begin
        feed_fwd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_word_d  = head_i.text ^ ks_q[head_i.pos];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    work_d = work_q;
    if (load) begin
      work_d = init_w;
    end else if (state_q == S_RUN) begin
      work_d = round_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (feed_fwd) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init_w[i];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign crypt_word_o = out_word_q;

endmodule

// ===== src/chacha20_stream_cipher.sv =====
// path: a word in the middle of a block passes through the queue and the output register
// a word that opens a block also waits on the rounds, the feed-forward and the emit state
// throughput: one word a cycle within a block while the output is not stalled; the first
// word of a block waits on one shared half-round unit that alternates column and diagonal rounds
// reset: asynchronous, active low; counters, queue and registers clear, keystream not
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// chacha20 keystream xor over a stream of 32-bit words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chacha20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] text_word_i,
  input  logic        message_start_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crypt_word_o
);

  // key and nonce registers, picked up at each block generation
  logic [63:0] key_01_q, key_23_q, key_45_q, key_67_q, nonce_01_q;
  logic [31:0] nonce_2_q;
  cc20_pkg::cfg_t cfg;

  // front to queue and queue to back
  logic             push, pop, fifo_empty, fifo_full;
  cc20_pkg::entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_01_q   <= '0;
      key_23_q   <= '0;
      key_45_q   <= '0;
      key_67_q   <= '0;
      nonce_01_q <= '0;
      nonce_2_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cc20_pkg::REG_KEY_01:   key_01_q   <= cfg_wdata_i;
        cc20_pkg::REG_KEY_23:   key_23_q   <= cfg_wdata_i;
        cc20_pkg::REG_KEY_45:   key_45_q   <= cfg_wdata_i;
        cc20_pkg::REG_KEY_67:   key_67_q   <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_01: nonce_01_q <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_2:  nonce_2_q  <= cfg_wdata_i[31:0];
        // writes past the last register are dropped
        default: ;
      endcase
    end
  end

  // low half is the even key word, high half the odd one
  assign cfg.key[0]   = key_01_q[31:0];
  assign cfg.key[1]   = key_01_q[63:32];
  assign cfg.key[2]   = key_23_q[31:0];
  assign cfg.key[3]   = key_23_q[63:32];
  assign cfg.key[4]   = key_45_q[31:0];
  assign cfg.key[5]   = key_45_q[63:32];
  assign cfg.key[6]   = key_67_q[31:0];
  assign cfg.key[7]   = key_67_q[63:32];
  assign cfg.nonce[0] = nonce_01_q[31:0];
  assign cfg.nonce[1] = nonce_01_q[63:32];
  assign cfg.nonce[2] = nonce_2_q;

  // front end: counts words and blocks, flags the first word of each block
  cc20_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .text_word_i     (text_word_i),
    .message_start_i (message_start_i),
    .in_stall_o      (in_stall_o),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  // short queue lets the front take transfers during block generation until it is full
  cc20_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // back end: rounds, feed-forward, keystream buffer and output register
  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head_entry),
    .empty_i      (fifo_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .crypt_word_o (crypt_word_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== src/cc20_checker.sv =====
// ----------------------------------------------------------------------------
// cc20_checker
// port-level checks on the chacha20 stream cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chacha20_stream_cipher_assert.svh"

module cc20_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] crypt_word_o
);

  // nothing offered on the output once reset has been seen low
  `CC20_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_o, "output valid in reset")

  // queue is empty when reset lets go
  `CC20_ASSERT_ALWAYS(a_ready_after_reset, clk_i, $rose(rst_ni) |-> !in_stall_o, "stall after reset")

  // a stalled result stays offered
  `CC20_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output valid dropped")

  // a stalled result keeps its value
  `CC20_ASSERT(a_out_word_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(crypt_word_o), "output word changed")

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);
